/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, prop, msg)
`endif
`endif

/* rtl/core/pso_pkg.sv */
package pso_pkg;

  localparam int unsigned FitW = 63;
  localparam logic [62:0] BestReset = 63'd327680000000;
  localparam logic [62:0] FitMax = {63{1'b1}};

  localparam logic [2:0] RegInertia = 3'd0;
  localparam logic [2:0] RegPGain   = 3'd1;
  localparam logic [2:0] RegGGain   = 3'd2;
  localparam logic [2:0] RegTargetX = 3'd3;
  localparam logic [2:0] RegTargetY = 3'd4;
  localparam logic [2:0] RegTargetZ = 3'd5;

  localparam logic FuncLoad = 1'b0;
  localparam logic FuncStep = 1'b1;

  typedef struct packed {
    logic              func;
    logic [3:0]        particle;
    logic signed [31:0] load_pos_x;
    logic signed [31:0] load_pos_y;
    logic signed [31:0] load_pos_z;
    logic signed [31:0] load_vel_x;
    logic signed [31:0] load_vel_y;
    logic signed [31:0] load_vel_z;
  } in_word_t;

  typedef struct packed {
    logic [62:0]        fitness;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] best_x;
    logic signed [31:0] best_y;
    logic signed [31:0] best_z;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_FIT, ST_BEST, ST_VEL, ST_DONE
  } state_t;

  // Commands from the controller, decoded from its state.
  typedef struct packed {
    logic capture;   // take the input word
    logic load;      // write the loaded particle
    logic read;      // read the particle from the tables
    logic fit;       // compute one fitness term
    logic best;      // fold fitness into the bests
    logic vel;       // compute one velocity lane and write back
    logic result;    // build the result word
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic       is_step;
    logic       in_range;
  } status_t;

endpackage

/* rtl/core/pso_ctrl.sv */
module pso_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  pso_pkg::status_t  status,
  output pso_pkg::cmd_t     cmd
);

  pso_pkg::state_t state, state_next;
  logic [1:0] axis, axis_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pso_pkg::ST_IDLE;
      axis <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      axis <= axis_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    axis_next = axis;
    cmd = '0;
    cmd.axis = axis;
    out_valid_next = out_valid && out_stall;
    in_stall = (state != pso_pkg::ST_IDLE);
    case (state)
      pso_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = pso_pkg::ST_READ;
        end
      end
      pso_pkg::ST_READ: begin
        axis_next = 2'd0;
        if (!status.in_range) begin
          state_next = pso_pkg::ST_DONE;
        end else if (!status.is_step) begin
          cmd.load = 1'b1;
          state_next = pso_pkg::ST_DONE;
        end else begin
          cmd.read = 1'b1;
          state_next = pso_pkg::ST_FIT;
        end
      end
      pso_pkg::ST_FIT: begin
        cmd.fit = 1'b1;
        axis_next = axis + 2'd1;
        if (axis == 2'd2) begin
          axis_next = 2'd0;
          state_next = pso_pkg::ST_BEST;
        end
      end
      pso_pkg::ST_BEST: begin
        cmd.best = 1'b1;
        state_next = pso_pkg::ST_VEL;
      end
      pso_pkg::ST_VEL: begin
        cmd.vel = 1'b1;
        axis_next = axis + 2'd1;
        if (axis == 2'd2) begin
          axis_next = 2'd0;
          state_next = pso_pkg::ST_DONE;
        end
      end
      pso_pkg::ST_DONE: begin
        if (!(out_valid && out_stall)) begin
          cmd.result = 1'b1;
          out_valid_next = 1'b1;
          state_next = pso_pkg::ST_IDLE;
        end
      end
      default: state_next = pso_pkg::ST_IDLE;
    endcase
  end

endmodule

/* rtl/core/pso_datapath.sv */
`include "assert_macros.svh"
module pso_datapath #(
  parameter int unsigned NUM_PARTICLES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  pso_pkg::in_word_t   in_word,
  input  pso_pkg::cmd_t       cmd,
  output pso_pkg::status_t    status,
  output pso_pkg::out_word_t  out_word
);

  localparam int unsigned PW = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;

  logic [18:0] w_reg, g1_reg, g2_reg;
  logic signed [31:0] tgt [3];

  pso_pkg::in_word_t req;
  logic [PW-1:0] pidx;

  // One row per particle holds the x, y and z lanes.
  logic [2:0][31:0] pos_mem [NUM_PARTICLES];
  logic [2:0][31:0] vel_mem [NUM_PARTICLES];
  logic [2:0][31:0] pb_mem  [NUM_PARTICLES];
  logic [62:0] pbf_mem [NUM_PARTICLES];
  logic [NUM_PARTICLES-1:0] pb_valid;

  logic signed [31:0] pos [3];
  logic signed [31:0] vel [3];
  logic signed [31:0] pb [3];
  logic [62:0] pbf;
  logic signed [31:0] gb [3];
  logic [62:0] gbf;
  logic [64:0] fit_acc;
  logic [62:0] fit;
  logic signed [31:0] new_pos [3];

  logic signed [32:0] d;
  logic [32:0] dmag;
  logic [65:0] sq;
  logic [49:0] sqq;
  logic [55:0] term;
  logic signed [32:0] dpb, dgb;
  logic signed [52:0] acc;
  logic signed [31:0] nv;
  logic [62:0] fit_sat;

  assign pidx = req.particle[PW-1:0];
  assign status.is_step = (req.func == pso_pkg::FuncStep);
  assign status.in_range = ({28'd0, req.particle} < 32'(NUM_PARTICLES));

  always_ff @(posedge clk) begin
    if (rst) begin
      w_reg <= 19'd32768;
      g1_reg <= 19'd65536;
      g2_reg <= 19'd65536;
      tgt[0] <= 32'sd3604480;
      tgt[1] <= 32'sd1638400;
      tgt[2] <= 32'sd983040;
    end else if (cfg_we) begin
      case (cfg_index)
        pso_pkg::RegInertia: w_reg <= cfg_data[18:0];
        pso_pkg::RegPGain:   g1_reg <= cfg_data[18:0];
        pso_pkg::RegGGain:   g2_reg <= cfg_data[18:0];
        pso_pkg::RegTargetX: tgt[0] <= cfg_data;
        pso_pkg::RegTargetY: tgt[1] <= cfg_data;
        pso_pkg::RegTargetZ: tgt[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // One squared distance term per cycle.
  always_comb begin
    d = 33'(pos[cmd.axis]) - 33'(tgt[cmd.axis]);
    dmag = d[32] ? 33'(-d) : 33'(d);
    sq = 66'(dmag) * 66'(dmag);
    sqq = sq[65:16];
    case (cmd.axis)
      2'd0: term = 56'(sqq) * 56'd10;
      2'd1: term = 56'(sqq) * 56'd20;
      default: term = 56'(sqq) * 56'd30;
    endcase
    fit_sat = (fit_acc > 65'(pso_pkg::FitMax)) ? pso_pkg::FitMax : fit_acc[62:0];
  end

  // One velocity lane per cycle, using the bests already updated.
  always_comb begin
    dpb = 33'(pb[cmd.axis]) - 33'(pos[cmd.axis]);
    dgb = 33'(gb[cmd.axis]) - 33'(pos[cmd.axis]);
    acc = 53'($signed({1'b0, w_reg})) * 53'(vel[cmd.axis])
        + 53'($signed({1'b0, g1_reg})) * 53'(dpb)
        + 53'($signed({1'b0, g2_reg})) * 53'(dgb);
    nv = acc[47:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pb_valid <= '0;
      gb[0] <= '0;
      gb[1] <= '0;
      gb[2] <= '0;
      gbf <= pso_pkg::BestReset;
    end else begin
      if (cmd.capture) req <= in_word;
      if (cmd.load) begin
        pos_mem[pidx] <= {req.load_pos_z, req.load_pos_y, req.load_pos_x};
        vel_mem[pidx] <= {req.load_vel_z, req.load_vel_y, req.load_vel_x};
        new_pos[0] <= req.load_pos_x;
        new_pos[1] <= req.load_pos_y;
        new_pos[2] <= req.load_pos_z;
        fit <= '0;
      end
      if (cmd.read) begin
        for (int k = 0; k < 3; k++) begin
          pos[k] <= pos_mem[pidx][k];
          vel[k] <= vel_mem[pidx][k];
          pb[k] <= pb_valid[pidx] ? pb_mem[pidx][k] : 32'sd0;
        end
        pbf <= pb_valid[pidx] ? pbf_mem[pidx] : pso_pkg::BestReset;
        fit_acc <= '0;
      end
      if (cmd.fit) fit_acc <= fit_acc + 65'(term);
      if (cmd.best) begin
        fit <= fit_sat;
        if (fit_sat < pbf) begin
          pb_valid[pidx] <= 1'b1;
          pbf_mem[pidx] <= fit_sat;
          for (int k = 0; k < 3; k++) begin
            pb_mem[pidx][k] <= pos[k];
            pb[k] <= pos[k];
          end
        end
        if (fit_sat < gbf) begin
          gbf <= fit_sat;
          for (int k = 0; k < 3; k++) gb[k] <= pos[k];
        end
      end
      if (cmd.vel) begin
        vel_mem[pidx][cmd.axis] <= nv;
        pos_mem[pidx][cmd.axis] <= pos[cmd.axis] + nv;
        new_pos[cmd.axis] <= pos[cmd.axis] + nv;
      end
      if (cmd.capture && !({28'd0, in_word.particle} < 32'(NUM_PARTICLES))) begin
        fit <= '0;
        new_pos[0] <= '0;
        new_pos[1] <= '0;
        new_pos[2] <= '0;
      end
      if (cmd.result) begin
        out_word.fitness <= fit;
        out_word.new_pos_x <= new_pos[0];
        out_word.new_pos_y <= new_pos[1];
        out_word.new_pos_z <= new_pos[2];
        out_word.best_x <= gb[0];
        out_word.best_y <= gb[1];
        out_word.best_z <= gb[2];
      end
    end
  end

  `ASSERT_NEVER(a_one_cmd, clk, rst, $countones({cmd.load, cmd.read, cmd.fit, cmd.best, cmd.vel}) > 1, "datapath commands overlap")
  `ASSERT_CLK(a_best_mono, clk, rst, cmd.best |=> gbf <= $past(gbf), "group best rose")
  `ASSERT_CLK(a_axis, clk, rst, (cmd.fit || cmd.vel) |-> cmd.axis != 2'd3, "axis out of range")

endmodule

/* rtl/core/pso_particle_update.sv */
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  pso_pkg::in_word_t
// out      output     out_valid/out_stall pso_pkg::out_word_t
// A step word passes through the table read, three fitness terms on one
// squaring multiplier, the best update, three velocity lanes on one
// multiply-accumulate, and the result register. A load word writes the
// tables and then the result register. The next word is accepted in the
// cycle after the result is registered, even if that result still waits.
// Reset is synchronous; the best table uses per-particle valid bits.
`include "assert_macros.svh"
module pso_particle_update #(
  parameter int unsigned NUM_PARTICLES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  pso_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pso_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  pso_pkg::cmd_t cmd;
  pso_pkg::status_t status;

  pso_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
  );

  pso_datapath #(.NUM_PARTICLES(NUM_PARTICLES)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_word(in_data), .cmd(cmd), .status(status),
    .out_word(out_data)
  );

  `ASSERT_CLK(a_hold, clk, rst, (out_valid && out_stall) |=> $stable(out_data), "stalled word changed")
  `ASSERT_CLK(a_valid, clk, rst, (out_valid && out_stall) |=> out_valid, "valid dropped")

endmodule
